// ===== sv/fdl_pkg.sv =====
// ----------------------------------------------------------------------------
// fdl_pkg
// Shared constants, register indexes and control/status types of the
// feedback delay line.
// ----------------------------------------------------------------------------
package fdl_pkg;

   // storage geometry
   localparam int STORE_DEPTH = 32768;
   localparam int USED_DEPTH  = STORE_DEPTH / 2;
   localparam int POS_W       = $clog2(STORE_DEPTH);
   localparam int ADDR_W      = $clog2(USED_DEPTH);
   localparam int CMP_W       = (POS_W > 16) ? POS_W : 16;
   localparam int IDX_W       = CMP_W + 2;
   localparam int CNT_W       = $clog2(POS_W);
   localparam logic [31:0] DEPTH_LIMIT = 32'(STORE_DEPTH);

   // sample arithmetic
   localparam int SAMPLE_W = 16;
   localparam int ACC_W    = SAMPLE_W + 1;
   localparam int PROD_W   = 2 * ACC_W;
   localparam int Q_SHIFT  = 15;

   // configuration port
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   typedef logic [1:0] fdl_reg_index_type;
   localparam fdl_reg_index_type REG_ENABLE  = 2'd0;
   localparam fdl_reg_index_type REG_DELAY   = 2'd1;
   localparam fdl_reg_index_type REG_GAIN    = 2'd2;
   localparam fdl_reg_index_type REG_LATENCY = 2'd3;

   typedef struct packed {
      logic        enable;
      logic [15:0] delay_samples;
      logic [15:0] feedback_gain;
      logic [11:0] latency_samples;
   } fdl_cfg_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;     // latch the input pair and mono sample
      logic rem_start;   // load the remainder unit with the position
      logic rem_step;    // one remainder bit
      logic set_err;
      logic clr_err;
      logic rd_pos;      // read store at the write position
      logic mac;         // add mono, scale by gain
      logic write_back;  // write entry, read the output tap, advance
      logic clr_step;    // one entry of the clearing pass
      logic load_wet;
      logic load_pass;
      logic load_mute;
   } fdl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic enable;
      logic need_reduce;
      logic delay_short;
      logic too_long;
      logic rem_done;
      logic clr_last;
      logic out_free;
   } fdl_status_type;

endpackage

// ===== sv/fdl_ram.sv =====
// ----------------------------------------------------------------------------
// fdl_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module fdl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/fdl_ctrl.sv =====
// ----------------------------------------------------------------------------
// fdl_ctrl
// Sequencer of the delay line: clearing pass, path decision, position
// reduction and the read-modify-write of one store entry per echoed sample.
// ----------------------------------------------------------------------------
module fdl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  fdl_pkg::fdl_status_type st,
   output fdl_pkg::fdl_cmd_type    cmd
);
   import fdl_pkg::*;

   typedef enum logic [8:0] {
      S_CLEAR  = 9'b000000001,
      S_IDLE   = 9'b000000010,
      S_DECIDE = 9'b000000100,
      S_REDUCE = 9'b000001000,
      S_MAC    = 9'b000010000,
      S_WRITE  = 9'b000100000,
      S_TAKE   = 9'b001000000,
      S_PASS   = 9'b010000000,
      S_MUTE   = 9'b100000000
   } fdl_state_type;

   fdl_state_type state_ff, state_in;
   logic          decide;

   // path decision happens on acceptance and after a reduction
   assign decide = ((state_ff == S_IDLE) && req_valid) || (state_ff == S_DECIDE);

   assign req_ready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (st.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cmd.capture = req_valid;
         end
         S_DECIDE: begin
         end
         S_REDUCE: begin
            cmd.rem_step = 1'b1;
            if (st.rem_done) begin
               state_in = S_DECIDE;
            end
         end
         S_MAC: begin
            cmd.mac  = 1'b1;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            cmd.write_back = 1'b1;
            state_in       = S_TAKE;
         end
         S_TAKE: begin
            if (st.out_free) begin
               cmd.load_wet = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_PASS: begin
            if (st.out_free) begin
               cmd.load_pass = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_MUTE: begin
            if (st.out_free) begin
               cmd.load_mute = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (decide) begin
         if (!st.enable) begin
            state_in = S_MUTE;
         end else if (st.need_reduce) begin
            cmd.rem_start = 1'b1;
            state_in      = S_REDUCE;
         end else if (st.delay_short) begin
            cmd.set_err = 1'b1;
            state_in    = S_PASS;
         end else if (st.too_long) begin
            cmd.clr_err = 1'b1;
            state_in    = S_PASS;
         end else begin
            cmd.clr_err = 1'b1;
            cmd.rd_pos  = 1'b1;
            state_in    = S_MAC;
         end
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/fdl_dp.sv =====
// ----------------------------------------------------------------------------
// fdl_dp
// Datapath of the delay line: input capture, bit-serial position modulo,
// gain multiply with saturation, tap index, store port muxing and the
// result register.
// ----------------------------------------------------------------------------
module fdl_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fdl_pkg::fdl_cmd_type                  cmd,
   output fdl_pkg::fdl_status_type               st,
   input  fdl_pkg::fdl_cfg_type                  cfg,
   input  logic signed [fdl_pkg::SAMPLE_W-1:0]   req_left_in,
   input  logic signed [fdl_pkg::SAMPLE_W-1:0]   req_right_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [fdl_pkg::SAMPLE_W-1:0]   rsp_left_out,
   output logic signed [fdl_pkg::SAMPLE_W-1:0]   rsp_right_out,
   output logic                                  rsp_processed,
   output logic                                  rsp_error_lit,
   output logic                                  ram_we,
   output logic [fdl_pkg::ADDR_W-1:0]            ram_waddr,
   output logic [fdl_pkg::SAMPLE_W-1:0]          ram_wdata,
   output logic                                  ram_re,
   output logic [fdl_pkg::ADDR_W-1:0]            ram_raddr,
   input  logic [fdl_pkg::SAMPLE_W-1:0]          ram_rdata
);
   import fdl_pkg::*;

   localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(32767);
   localparam logic signed [PROD_W-1:0] SAT_LO = -PROD_W'(32768);

   // sample and control registers
   logic signed [SAMPLE_W-1:0] left_ff, right_ff, mono_ff;
   logic [POS_W-1:0]           pos_ff;
   logic                       err_ff;
   logic [ADDR_W-1:0]          idx_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic [SAMPLE_W-1:0]        wdata_ff;
   logic                       bypass_ff;
   logic [ADDR_W-1:0]          clr_ff;
   logic [15:0]                rem_ff;
   logic [POS_W-1:0]           div_ff;
   logic [CNT_W-1:0]           rem_cnt_ff;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] left_out_ff, right_out_ff;
   logic                       proc_ff, err_out_ff;

   logic [ACC_W-1:0]           in_sum;
   logic signed [ACC_W-1:0]    acc;
   logic signed [PROD_W-1:0]   shifted;
   logic [SAMPLE_W-1:0]        sat_data;
   logic [IDX_W-1:0]           tap_sum, tap_idx, pos_inc, pos_next, delay_x;
   logic [16:0]                trial;
   logic                       trial_ge;
   logic [15:0]                rem_next;
   logic                       rem_last;
   logic [SAMPLE_W-1:0]        wet;

   // path status
   assign st.enable      = cfg.enable;
   assign st.need_reduce = (cfg.delay_samples != 16'd0) &&
                           (CMP_W'(pos_ff) >= CMP_W'(cfg.delay_samples));
   assign st.delay_short = cfg.delay_samples <= 16'(cfg.latency_samples);
   assign st.too_long    = (32'(cfg.delay_samples) << 1) > DEPTH_LIMIT;
   assign st.rem_done    = rem_last;
   assign st.clr_last    = (clr_ff == ADDR_W'(USED_DEPTH - 1));
   assign st.out_free    = !rsp_valid_ff || rsp_ready;

   // mono average, floor of half the sum
   assign in_sum = ACC_W'(req_left_in) + ACC_W'(req_right_in);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         left_ff  <= req_left_in;
         right_ff <= req_right_in;
         mono_ff  <= {req_left_in[SAMPLE_W-1] ^ req_right_in[SAMPLE_W-1] ^ in_sum[ACC_W-1]
                      ? in_sum[ACC_W-1] : in_sum[ACC_W-1], in_sum[ACC_W-2:1]};
      end
   end

   // remainder unit, one quotient bit per cycle
   assign trial    = {rem_ff, div_ff[POS_W-1]};
   assign trial_ge = trial >= {1'b0, cfg.delay_samples};
   assign rem_next = trial_ge ? 16'(trial - {1'b0, cfg.delay_samples}) : trial[15:0];
   assign rem_last = (rem_cnt_ff == CNT_W'(POS_W - 1));

   always_ff @(posedge clock) begin
      if (cmd.rem_start) begin
         rem_ff     <= 16'd0;
         div_ff     <= pos_ff;
         rem_cnt_ff <= '0;
      end else if (cmd.rem_step) begin
         rem_ff     <= rem_next;
         div_ff     <= div_ff << 1;
         rem_cnt_ff <= rem_cnt_ff + CNT_W'(1);
      end
   end

   // tap index and next write position, both below the delay length
   assign delay_x  = IDX_W'(cfg.delay_samples);
   assign tap_sum  = IDX_W'(pos_ff) + IDX_W'(cfg.latency_samples) + IDX_W'(1);
   assign tap_idx  = (tap_sum >= delay_x) ? tap_sum - delay_x : tap_sum;
   assign pos_inc  = IDX_W'(pos_ff) + IDX_W'(1);
   assign pos_next = (pos_inc == delay_x) ? '0 : pos_inc;

   // feedback sum times gain
   assign acc = $signed({ram_rdata[SAMPLE_W-1], ram_rdata}) +
                $signed({mono_ff[SAMPLE_W-1], mono_ff});

   always_ff @(posedge clock) begin
      if (cmd.mac) begin
         prod_ff <= acc * $signed({1'b0, cfg.feedback_gain});
         idx_ff  <= ADDR_W'(tap_idx);
      end
   end

   // scale back to Q1.15 and saturate
   assign shifted  = prod_ff >>> Q_SHIFT;
   assign sat_data = (shifted > SAT_HI) ? SAMPLE_W'(SAT_HI) :
                     (shifted < SAT_LO) ? SAMPLE_W'(SAT_LO) : shifted[SAMPLE_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.write_back) begin
         wdata_ff  <= sat_data;
         bypass_ff <= (idx_ff == ADDR_W'(pos_ff));
      end
   end

   // write position and error flag
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         err_ff <= 1'b0;
      end else begin
         if (cmd.rem_step && rem_last) begin
            pos_ff <= POS_W'(rem_next);
         end else if (cmd.write_back) begin
            pos_ff <= POS_W'(pos_next);
         end
         if (cmd.set_err) begin
            err_ff <= 1'b1;
         end else if (cmd.clr_err) begin
            err_ff <= 1'b0;
         end
      end
   end

   // clearing pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= clr_ff + ADDR_W'(1);
      end
   end

   // store port muxing
   assign ram_we    = cmd.clr_step || cmd.write_back;
   assign ram_waddr = cmd.clr_step ? clr_ff : ADDR_W'(pos_ff);
   assign ram_wdata = cmd.clr_step ? '0 : sat_data;
   assign ram_re    = cmd.rd_pos || cmd.write_back;
   assign ram_raddr = cmd.rd_pos ? ADDR_W'(pos_ff) : idx_ff;

   // tap read back, freshly written entry when the tap hits the write position
   assign wet = bypass_ff ? wdata_ff : ram_rdata;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_wet || cmd.load_pass || cmd.load_mute) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_wet) begin
         left_out_ff  <= wet;
         right_out_ff <= wet;
         proc_ff      <= 1'b1;
         err_out_ff   <= err_ff;
      end else if (cmd.load_pass) begin
         left_out_ff  <= left_ff;
         right_out_ff <= right_ff;
         proc_ff      <= 1'b0;
         err_out_ff   <= err_ff;
      end else if (cmd.load_mute) begin
         left_out_ff  <= '0;
         right_out_ff <= '0;
         proc_ff      <= 1'b0;
         err_out_ff   <= err_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = left_out_ff;
   assign rsp_right_out = right_out_ff;
   assign rsp_processed = proc_ff;
   assign rsp_error_lit = err_out_ff;

endmodule

// ===== sv/feedback_delay_line_core.sv =====
// ----------------------------------------------------------------------------
// feedback_delay_line_core
// Mono feedback echo for stereo Q1.15 samples with an APB-style register
// port, a sequencer, a datapath and the delay store.
// ----------------------------------------------------------------------------
// One stereo pair goes in per transaction and exactly one result comes out.
// For a processed sample the store entry at the write position is read,
// summed with the mono sample and multiplied by the gain, then written back
// while the output tap is read on the second port of the store; the next
// pair is taken only once the result is in the output register. Disabled,
// too-short and too-long delay settings bypass the store. After the delay
// length is lowered to or below the current write position, the first sample
// first passes through the one-bit-per-cycle modulo unit. The result waits
// in an output register so the next pair is taken while it is held. After
// reset the store is zeroed by a clearing pass over STORE_DEPTH/2 entries
// (16384 at the default depth) during which req_ready stays low; register
// writes are taken throughout. Write registers only while the block is
// idle.
// ----------------------------------------------------------------------------
module feedback_delay_line_core (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [fdl_pkg::SAMPLE_W-1:0] req_left_in,
   input  logic signed [fdl_pkg::SAMPLE_W-1:0] req_right_in,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [fdl_pkg::SAMPLE_W-1:0] rsp_left_out,
   output logic signed [fdl_pkg::SAMPLE_W-1:0] rsp_right_out,
   output logic                                rsp_processed,
   output logic                                rsp_error_lit,
   // register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fdl_pkg::CSR_AW-1:0]          paddr,
   input  logic [fdl_pkg::CSR_DW-1:0]          pwdata,
   output logic [fdl_pkg::CSR_DW-1:0]          prdata,
   output logic                                pready
);
   import fdl_pkg::*;

   fdl_cfg_type       cfg_ff;
   fdl_reg_index_type reg_index;
   fdl_cmd_type       cmd;
   fdl_status_type    st;

   logic                ram_we, ram_re;
   logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
   logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;

   assign pready    = 1'b1;
   assign reg_index = paddr[3:2];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (psel && penable && pwrite) begin
         case (reg_index)
            REG_ENABLE:  cfg_ff.enable          <= pwdata[0];
            REG_DELAY:   cfg_ff.delay_samples   <= pwdata[15:0];
            REG_GAIN:    cfg_ff.feedback_gain   <= pwdata[15:0];
            REG_LATENCY: cfg_ff.latency_samples <= pwdata[11:0];
            default: begin
            end
         endcase
      end
   end

   // register readback
   always_comb begin
      case (reg_index)
         REG_ENABLE:  prdata = CSR_DW'(cfg_ff.enable);
         REG_DELAY:   prdata = CSR_DW'(cfg_ff.delay_samples);
         REG_GAIN:    prdata = CSR_DW'(cfg_ff.feedback_gain);
         REG_LATENCY: prdata = CSR_DW'(cfg_ff.latency_samples);
         default:     prdata = '0;
      endcase
   end

   fdl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   fdl_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .st            (st),
      .cfg           (cfg_ff),
      .req_left_in   (req_left_in),
      .req_right_in  (req_right_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out),
      .rsp_processed (rsp_processed),
      .rsp_error_lit (rsp_error_lit),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata),
      .ram_re        (ram_re),
      .ram_raddr     (ram_raddr),
      .ram_rdata     (ram_rdata)
   );

   // delay store, only half of STORE_DEPTH is built and addressed
   fdl_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (USED_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule

// ===== sim/fdl_echo_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdl_echo_checker
// Watches the sample, result and register channels of the feedback delay
// line, keeps its own copy of the echo store, position and error flag, and
// checks every result against the oldest predicted sample.
// ----------------------------------------------------------------------------
module fdl_echo_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic signed [fdl_pkg::SAMPLE_W-1:0] req_left_in,
   input  logic signed [fdl_pkg::SAMPLE_W-1:0] req_right_in,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [fdl_pkg::SAMPLE_W-1:0] rsp_left_out,
   input  logic signed [fdl_pkg::SAMPLE_W-1:0] rsp_right_out,
   input  logic                                rsp_processed,
   input  logic                                rsp_error_lit,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic                                pready,
   input  logic [fdl_pkg::CSR_AW-1:0]          paddr,
   input  logic [fdl_pkg::CSR_DW-1:0]          pwdata,
   output int                                  fail_count,
   output int                                  pending_count
);
   import fdl_pkg::*;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
      logic                       processed;
      logic                       error_lit;
   } echo_result_type;

   // shadow of the block state and registers
   logic signed [SAMPLE_W-1:0] echo_store [STORE_DEPTH];
   int unsigned                write_pos;
   logic                       err_flag;
   fdl_cfg_type                cfg;
   echo_result_type            echo_expected_q[$];
   int                         mismatches;

   // one stereo pair through the echo: updates the shadow state
   function automatic echo_result_type echo_sample(input logic signed [SAMPLE_W-1:0] left,
                                                   input logic signed [SAMPLE_W-1:0] right);
      echo_result_type res;
      longint          mono;
      longint          acc;
      longint          scaled;
      int unsigned     dly;
      int unsigned     tap;
      res.left_out  = left;
      res.right_out = right;
      res.processed = 1'b0;
      if (!cfg.enable) begin
         res.left_out  = '0;
         res.right_out = '0;
      end else begin
         mono = (longint'(left) + longint'(right)) >>> 1;
         dly  = cfg.delay_samples;
         if (dly != 0)
            write_pos = write_pos % dly;
         if (dly <= cfg.latency_samples) begin
            err_flag = 1'b1;
         end else begin
            err_flag = 1'b0;
            // delay must fit twice into the store
            if (2 * dly <= STORE_DEPTH) begin
               tap    = (write_pos + 1 + cfg.latency_samples) % dly;
               acc    = longint'(echo_store[write_pos]) + mono;
               scaled = (acc * longint'(cfg.feedback_gain)) >>> Q_SHIFT;
               if (scaled > 32767)
                  scaled = 32767;
               else if (scaled < -32768)
                  scaled = -32768;
               echo_store[write_pos] = 16'(scaled);
               res.left_out  = echo_store[tap];
               res.right_out = echo_store[tap];
               res.processed = 1'b1;
               write_pos = (write_pos + 1) % dly;
            end
         end
      end
      res.error_lit = err_flag;
      return res;
   endfunction

   // snoop register writes, compare results, predict accepted pairs
   always @(posedge clock) begin
      echo_result_type want;
      echo_result_type got;
      if (reset) begin
         echo_expected_q.delete();
         foreach (echo_store[i])
            echo_store[i] = '0;
         write_pos  = 0;
         err_flag   = 1'b0;
         cfg        = '0;
         mismatches = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (fdl_reg_index_type'(paddr >> 2))
               REG_ENABLE:  cfg.enable          = pwdata[0];
               REG_DELAY:   cfg.delay_samples   = pwdata[15:0];
               REG_GAIN:    cfg.feedback_gain   = pwdata[15:0];
               REG_LATENCY: cfg.latency_samples = pwdata[11:0];
               default: ;
            endcase
         end
         // results first: a result never belongs to a pair taken at the same edge
         if (rsp_valid && rsp_ready) begin
            got.left_out  = rsp_left_out;
            got.right_out = rsp_right_out;
            got.processed = rsp_processed;
            got.error_lit = rsp_error_lit;
            if (echo_expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result left %0d right %0d processed %0b error %0b",
                           $realtime, got.left_out, got.right_out, got.processed,
                           got.error_lit);
            end else begin
               want = echo_expected_q.pop_front();
               if (got.left_out !== want.left_out || got.right_out !== want.right_out ||
                   got.processed !== want.processed || got.error_lit !== want.error_lit) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch expected left %0d right %0d processed %0b error %0b,",
                              $realtime, want.left_out, want.right_out, want.processed,
                              want.error_lit,
                              " got left %0d right %0d processed %0b error %0b",
                              got.left_out, got.right_out, got.processed, got.error_lit);
               end
            end
         end
         if (req_valid && req_ready)
            echo_expected_q.push_back(echo_sample(req_left_in, req_right_in));
      end
      fail_count    <= mismatches;
      pending_count <= echo_expected_q.size();
   end

endmodule

// ===== sim/tb_feedback_delay_line_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_feedback_delay_line_core
// Drives stereo pairs and register settings into the feedback delay line,
// with random gaps on both channels, and reports the checker's verdict.
// Directed settings cover muting, zero and short delays, too-long delays,
// reading back the freshly written entry and gain above one; random phases
// follow, mostly echo settings with random content.
// ----------------------------------------------------------------------------
module tb_feedback_delay_line_core;
   import fdl_pkg::*;

   localparam int IDLE_LIMIT   = 100000;
   localparam int TARGET_PAIRS = 650;

   typedef enum int {MODE_MUTED, MODE_SHORT, MODE_LONG, MODE_ECHO} phase_mode_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_left_in;
   logic signed [SAMPLE_W-1:0] req_right_in;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [SAMPLE_W-1:0] rsp_left_out;
   logic signed [SAMPLE_W-1:0] rsp_right_out;
   logic                       rsp_processed;
   logic                       rsp_error_lit;
   logic                       psel;
   logic                       penable;
   logic                       pwrite;
   logic [CSR_AW-1:0]          paddr;
   logic [CSR_DW-1:0]          pwdata;
   logic [CSR_DW-1:0]          prdata;
   logic                       pready;

   int fail_count;
   int pending_count;
   int pairs_sent;
   int idle_cycles;
   bit no_idle;

   feedback_delay_line_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_left_in   (req_left_in),
      .req_right_in  (req_right_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out),
      .rsp_processed (rsp_processed),
      .rsp_error_lit (rsp_error_lit),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   fdl_echo_checker u_echo_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_left_in   (req_left_in),
      .req_right_in  (req_right_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out),
      .rsp_processed (rsp_processed),
      .rsp_error_lit (rsp_error_lit),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .pready        (pready),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog on cycles without any transaction
   initial idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int unsigned draw_gap();
      return no_idle ? 0 : $urandom_range(0, 7);
   endfunction

   // mostly full-range samples, now and then an extreme
   function automatic logic [SAMPLE_W-1:0] draw_sample();
      case ($urandom_range(0, 9))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return $urandom_range(0, 1) ? 16'h0000 : 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   // result side stalls
   initial begin
      int unsigned gap;
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // one stereo pair, returns at the edge it is taken
   task automatic send_pair(input logic [SAMPLE_W-1:0] left, input logic [SAMPLE_W-1:0] right);
      int unsigned gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_left_in  <= left;
      req_right_in <= right;
      do @(posedge clock); while (!(req_valid && req_ready));
      pairs_sent++;
   endtask

   // stop sending and wait until every result is back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (8) @(posedge clock);
   endtask

   // setup then access phase; psel stays high across back-to-back writes
   task automatic csr_write(input fdl_reg_index_type idx, input logic [CSR_DW-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   // idle the block, then write all four registers
   task automatic configure(input logic en, input logic [15:0] dly, input logic [15:0] gain,
                            input logic [11:0] lat, input bit noisy);
      logic [31:0] hi;
      drain_results();
      hi = noisy ? $urandom : 32'd0;
      csr_write(REG_ENABLE,  {hi[30:0], en});
      csr_write(REG_DELAY,   {hi[15:0], dly});
      csr_write(REG_GAIN,    {hi[15:0], gain});
      csr_write(REG_LATENCY, {hi[19:0], lat});
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // stimulus and verdict
   initial begin
      phase_mode_type mode;
      logic           en;
      logic [15:0]    dly;
      logic [15:0]    gain;
      logic [11:0]    lat;
      int unsigned    lat_top;
      int unsigned    count;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_left_in  <= '0;
      req_right_in <= '0;
      psel         <= 1'b0;
      penable      <= 1'b0;
      pwrite       <= 1'b0;
      paddr        <= '0;
      pwdata       <= '0;
      no_idle       = 1'b0;
      pairs_sent    = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // muted after reset
      send_pair(16'h7fff, 16'h8000);
      send_pair(16'hffff, 16'h0000);
      // zero delay: error, pass through
      configure(1'b1, 16'd0, 16'd32768, 12'd0, 1'b0);
      send_pair(16'h8000, 16'h8000);
      send_pair(16'h7fff, 16'h7fff);
      // delay equal to latency: error, pass through
      configure(1'b1, 16'd3, 16'd32768, 12'd3, 1'b0);
      send_pair(16'h1234, 16'hedcb);
      send_pair(16'h0001, 16'hffff);
      // muted while the error flag is held
      configure(1'b0, 16'd3, 16'd32768, 12'd3, 1'b0);
      send_pair(16'h5555, 16'haaaa);
      // delay too long for the store: error clears, pass through
      configure(1'b1, 16'hffff, 16'd32768, 12'd0, 1'b0);
      send_pair(16'h7fff, 16'h0001);
      send_pair(16'h8000, 16'hffff);
      // delay one past latency: the fresh entry is read back
      configure(1'b1, 16'd1, 16'd32768, 12'd0, 1'b0);
      send_pair(16'h4000, 16'h4000);
      send_pair(16'h8000, 16'h7fff);
      // gain just under two, saturation both ways
      configure(1'b1, 16'd4, 16'hffff, 12'd2, 1'b0);
      send_pair(16'h7fff, 16'h7fff);
      send_pair(16'h7fff, 16'h7fff);
      send_pair(16'h8000, 16'h8000);
      send_pair(16'h8000, 16'h8000);
      // longest usable delay, largest latency, zero gain
      configure(1'b1, 16'd16384, 16'd0, 12'd4095, 1'b0);
      send_pair(16'h7fff, 16'h8000);
      send_pair(16'h0100, 16'hff00);

      // random phases, mostly echo settings
      while (pairs_sent < TARGET_PAIRS) begin
         case ($urandom_range(0, 9))
            0: mode = MODE_MUTED;
            1: mode = MODE_SHORT;
            2: mode = MODE_LONG;
            default: mode = MODE_ECHO;
         endcase
         en = 1'b1;
         case ($urandom_range(0, 3))
            0: gain = 16'd32768;
            1: gain = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
            default: gain = 16'($urandom);
         endcase
         case (mode)
            MODE_MUTED: begin
               en  = 1'b0;
               dly = 16'($urandom_range(0, 64));
               lat = 12'($urandom_range(0, 8));
            end
            MODE_SHORT: begin
               lat = 12'($urandom_range(1, 4095));
               dly = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, lat));
            end
            MODE_LONG: begin
               dly = 16'($urandom_range(16385, 65535));
               lat = 12'($urandom);
            end
            default: begin
               dly     = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 16384))
                                                     : 16'($urandom_range(1, 64));
               lat_top = (dly - 1 > 4095) ? 4095 : dly - 1;
               lat     = ($urandom_range(0, 3) == 0) ? 12'(lat_top)
                                                     : 12'($urandom_range(0, lat_top));
            end
         endcase
         configure(en, dly, gain, lat, 1'($urandom_range(0, 1)));
         no_idle = ($urandom_range(0, 3) == 0);
         count   = $urandom_range(10, 45);
         repeat (count) send_pair(draw_sample(), draw_sample());
      end

      drain_results();
      if (fail_count == 0 && pending_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/fdl_pkg.sv
sv/fdl_ram.sv
sv/fdl_ctrl.sv
sv/fdl_dp.sv
sv/feedback_delay_line_core.sv
sim/fdl_echo_checker.sv
sim/tb_feedback_delay_line_core.sv
